[rtl/core/ipv4_prefix_trie_defines.svh]
// Assertion macros shared by the trie RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef IPV4_PREFIX_TRIE_DEFINES_SVH
`define IPV4_PREFIX_TRIE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define PT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ipv4_prefix_trie: assertion failed");

// A condition that must be followed by another in the next cycle.
`define PT_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error("ipv4_prefix_trie: assertion failed");

`endif

[rtl/core/pfx_trie_pkg.sv]
// Types and constants of the prefix trie.
// Used by ipv4_prefix_trie; depends on nothing.
package pfx_trie_pkg;

    localparam int NODES    = 1024;
    localparam int KEY_BITS = 32;
    localparam int NODE_W   = $clog2(NODES);
    localparam int CNT_W    = $clog2(NODES + 1);
    localparam int LVL_W    = $clog2(KEY_BITS + 1);
    localparam int IDX_W    = $clog2(KEY_BITS);

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]          operation;
        logic [KEY_BITS-1:0] key;
        logic [KEY_BITS-1:0] mask;
        logic [7:0]          value;
    } t_req;

    typedef struct packed {
        logic       status;
        logic       found;
        logic [7:0] match_value;
    } t_rsp;

    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [NODE_W-1:0] parent;
        logic [7:0]        value;
        logic              has;
    } t_node;

    // Bit of a key-wide vector at a trie level; levels past the last key bit read as zero.
    function automatic logic level_bit(input logic [KEY_BITS-1:0] vec,
                                       input logic [LVL_W-1:0] lvl);
        logic [LVL_W-1:0] idx;
        idx = LVL_W'(KEY_BITS - 1) - lvl;
        if (lvl < LVL_W'(KEY_BITS)) begin
            return vec[idx[IDX_W-1:0]];
        end
        return 1'b0;
    endfunction

endpackage

[rtl/core/ipv4_prefix_trie.sv]
// Binary trie for longest-prefix match over 32-bit keys, with node and free-list memories.
// Depends on pfx_trie_pkg and ipv4_prefix_trie_defines.svh.
//
//  channel   signals                       moves
//  request   i_valid / o_ready / i_data    one word: operation, key, mask, value
//  response  o_valid / i_ready / o_data    one word: status, found, match_value
//
// One word is worked on at a time. A find reads one node per trie level walked; an insert
// reads one per level walked, then for each node added takes an index from the free list and
// links it into its parent; a delete reads one per level, then frees and unlinks each
// pruned node. Each read goes through the node memory's single registered read port. After
// reset the block sweeps both memories before it takes its first word. A stalled response is
// held in an output register; the next request is taken while it waits.
`include "ipv4_prefix_trie_defines.svh"

module ipv4_prefix_trie (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pfx_trie_pkg::t_req   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pfx_trie_pkg::t_rsp   o_data
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_FIND, S_INS, S_ALLOC, S_ALLOC2, S_DEL, S_PRUNE_RD, S_PRUNE, S_OUT
    } t_state;

    // Node memory holds both child links, the parent link and the stored value.
    pfx_trie_pkg::t_node node_mem [pfx_trie_pkg::NODES];
    logic [pfx_trie_pkg::NODE_W-1:0] free_mem [pfx_trie_pkg::NODES];

    t_state                          r_state, n_state;
    pfx_trie_pkg::t_req              r_req, n_req;
    pfx_trie_pkg::t_rsp              r_rsp, n_rsp;
    pfx_trie_pkg::t_rsp              r_out, n_out;
    logic                            r_ovalid, n_ovalid;
    logic [pfx_trie_pkg::NODE_W-1:0] r_node, n_node;
    logic [pfx_trie_pkg::LVL_W-1:0]  r_lvl, n_lvl;
    logic [pfx_trie_pkg::CNT_W-1:0]  r_fc, n_fc;
    logic [pfx_trie_pkg::NODE_W-1:0] r_clr, n_clr;
    pfx_trie_pkg::t_node             r_word, n_word;

    pfx_trie_pkg::t_node             r_q;
    logic [pfx_trie_pkg::NODE_W-1:0] r_fsq;

    logic                            rd_en;
    logic [pfx_trie_pkg::NODE_W-1:0] rd_addr;
    logic                            wr_en;
    logic [pfx_trie_pkg::NODE_W-1:0] wr_addr;
    pfx_trie_pkg::t_node             wr_data;
    logic                            fs_rd_en;
    logic                            fs_wr_en;
    logic [pfx_trie_pkg::NODE_W-1:0] fs_addr;
    logic [pfx_trie_pkg::NODE_W-1:0] fs_wdata;

    logic                            kb;
    logic                            mb;
    logic [pfx_trie_pkg::NODE_W-1:0] nx;
    pfx_trie_pkg::t_node             upd;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // Key and mask bits at the current level, and the child that the key selects.
    assign kb = pfx_trie_pkg::level_bit(r_req.key, r_lvl);
    assign mb = pfx_trie_pkg::level_bit(r_req.mask, r_lvl);
    assign nx = kb ? r_q.right : r_q.left;

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_rsp    = r_rsp;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        n_node   = r_node;
        n_lvl    = r_lvl;
        n_fc     = r_fc;
        n_clr    = r_clr;
        n_word   = r_word;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_node;
        wr_data  = r_q;
        fs_rd_en = 1'b0;
        fs_wr_en = 1'b0;
        fs_addr  = '0;
        fs_wdata = '0;
        upd      = r_q;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                // Clear every node and seed the free list with indices one and up.
                wr_en    = 1'b1;
                wr_addr  = r_clr;
                wr_data  = '0;
                fs_wr_en = 1'b1;
                fs_addr  = r_clr;
                fs_wdata = r_clr + 1'b1;
                n_clr    = r_clr + 1'b1;
                if (r_clr == pfx_trie_pkg::NODE_W'(pfx_trie_pkg::NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_req   = i_data;
                    n_rsp   = '0;
                    n_node  = '0;
                    n_lvl   = '0;
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    case (i_data.operation)
                        pfx_trie_pkg::OP_FIND:   n_state = S_FIND;
                        pfx_trie_pkg::OP_INSERT: n_state = S_INS;
                        pfx_trie_pkg::OP_DELETE: n_state = S_DEL;
                        default: begin
                            n_rsp.status = 1'b1;
                            n_state      = S_OUT;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (r_q.has) begin
                    n_rsp.found       = 1'b1;
                    n_rsp.match_value = r_q.value;
                end
                if (nx == '0) begin
                    n_state = S_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = nx;
                    n_node  = nx;
                    n_lvl   = r_lvl + 1'b1;
                end
            end
            S_INS: begin
                if (mb) begin
                    if (nx == '0) begin
                        n_word  = r_q;
                        n_state = S_ALLOC;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = nx;
                        n_node  = nx;
                        n_lvl   = r_lvl + 1'b1;
                    end
                end else begin
                    n_state = S_OUT;
                    if (r_q.has) begin
                        n_rsp.status = 1'b1;
                    end else begin
                        wr_en         = 1'b1;
                        wr_data       = r_q;
                        wr_data.value = r_req.value;
                        wr_data.has   = 1'b1;
                    end
                end
            end
            S_ALLOC: begin
                // The image of the current node lives in r_word until it is written back.
                if (!mb) begin
                    wr_en         = 1'b1;
                    wr_data       = r_word;
                    wr_data.value = r_req.value;
                    wr_data.has   = 1'b1;
                    n_state       = S_OUT;
                end else if (r_fc == '0) begin
                    wr_en        = 1'b1;
                    wr_data      = r_word;
                    n_rsp.status = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    fs_rd_en = 1'b1;
                    fs_addr  = pfx_trie_pkg::NODE_W'(r_fc - 1'b1);
                    n_fc     = r_fc - 1'b1;
                    n_state  = S_ALLOC2;
                end
            end
            S_ALLOC2: begin
                wr_en   = 1'b1;
                wr_data = r_word;
                if (kb) begin
                    wr_data.right = r_fsq;
                end else begin
                    wr_data.left = r_fsq;
                end
                n_word        = '0;
                n_word.parent = r_node;
                n_node        = r_fsq;
                n_lvl         = r_lvl + 1'b1;
                n_state       = S_ALLOC;
            end
            S_DEL: begin
                if (mb) begin
                    if (nx == '0) begin
                        n_rsp.status = 1'b1;
                        n_state      = S_OUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = nx;
                        n_node  = nx;
                        n_lvl   = r_lvl + 1'b1;
                    end
                end else if (r_node == '0) begin
                    n_rsp.status = 1'b1;
                    n_state      = S_OUT;
                end else if (r_q.left != '0 || r_q.right != '0) begin
                    n_state = S_OUT;
                    if (r_q.has) begin
                        wr_en       = 1'b1;
                        wr_data     = r_q;
                        wr_data.has = 1'b0;
                    end else begin
                        n_rsp.status = 1'b1;
                    end
                end else begin
                    n_word  = r_q;
                    n_state = S_PRUNE_RD;
                end
            end
            S_PRUNE_RD: begin
                // Free the current leaf and fetch its parent.
                if (r_fc < pfx_trie_pkg::CNT_W'(pfx_trie_pkg::NODES)) begin
                    fs_wr_en = 1'b1;
                    fs_addr  = r_fc[pfx_trie_pkg::NODE_W-1:0];
                    fs_wdata = r_node;
                    n_fc     = r_fc + 1'b1;
                end
                rd_en   = 1'b1;
                rd_addr = r_word.parent;
                n_word  = '0;
                n_word.left = r_node;
                n_node  = r_word.parent;
                n_state = S_PRUNE;
            end
            S_PRUNE: begin
                // r_word.left carries the index of the child just freed.
                upd = r_q;
                if (r_q.right == r_word.left) begin
                    upd.right = '0;
                end else begin
                    upd.left = '0;
                end
                wr_en   = 1'b1;
                wr_data = upd;
                if (upd.left != '0 || upd.right != '0 || upd.has || r_node == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_word  = upd;
                    n_state = S_PRUNE_RD;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_out    = r_rsp;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ovalid <= 1'b0;
            r_fc     <= pfx_trie_pkg::CNT_W'(pfx_trie_pkg::NODES - 1);
            r_clr    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_fc     <= n_fc;
            r_clr    <= n_clr;
        end
        r_req  <= n_req;
        r_rsp  <= n_rsp;
        r_out  <= n_out;
        r_node <= n_node;
        r_lvl  <= n_lvl;
        r_word <= n_word;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= node_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fs_wr_en) begin
            free_mem[fs_addr] <= fs_wdata;
        end
        if (fs_rd_en) begin
            r_fsq <= free_mem[fs_addr];
        end
    end

    `PT_ASSERT(a_fc_range, r_fc <= pfx_trie_pkg::CNT_W'(pfx_trie_pkg::NODES - 1))
    `PT_ASSERT(a_root_kept, !(fs_wr_en && r_state == S_PRUNE_RD && r_node == '0))
    `PT_ASSERT(a_no_out_in_clear, !(r_state == S_CLR && r_ovalid))
    `PT_ASSERT_NEXT(a_one_at_a_time, i_valid && o_ready, !o_ready)

endmodule
